// ----- design/obod_pkg.sv -----
package obod_pkg;

	// defaults for the top-level parameters
	localparam int OCTAVES_DEF        = 10;
	localparam int BIN_INDEX_BITS_DEF = 10;

	// fixed field widths
	localparam int MAG_W       = 16;
	localparam int LEVEL_W     = 25;
	localparam int KEEP_W      = 16;
	localparam int RATIO_W     = 10;
	localparam int OCT_FIELD_W = 4;
	localparam int EVT_W       = 2;
	localparam int OUT_W       = 64;

	// configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	typedef enum logic [2:0] {
		REG_NOISE_FLOOR = 3'd0,
		REG_FAST_KEEP   = 3'd1,
		REG_SLOW_KEEP   = 3'd2,
		REG_RISE_RATIO  = 3'd3,
		REG_FALL_RATIO  = 3'd4
	} reg_idx_t;

	localparam logic [MAG_W-1:0]   NOISE_FLOOR_RST = 16'd0;
	localparam logic [KEEP_W-1:0]  FAST_KEEP_RST   = 16'd49152;
	localparam logic [KEEP_W-1:0]  SLOW_KEEP_RST   = 16'd64881;
	localparam logic [RATIO_W-1:0] RISE_RATIO_RST  = 10'd294;
	localparam logic [RATIO_W-1:0] FALL_RATIO_RST  = 10'd230;

	typedef enum logic [EVT_W-1:0] {
		EV_NONE    = 2'd0,
		EV_ONSET   = 2'd1,
		EV_RELEASE = 2'd2
	} band_event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_RD,
		ST_MUL,
		ST_ADD,
		ST_THR,
		ST_WB
	} state_t;

endpackage

// ----- design/obod_ram.sv -----
module obod_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/octave_band_onset_detector_core.sv -----
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: bin_index, bin_magnitude; tlast: frame_end
// m_*       out  m_tvalid/m_tready  tdata: octave, band_active, band_event, fast, slow;
//                                   tlast: last_octave
// apb       in   psel/penable       five registers at byte address 4*i, pready tied high
//
// while no frame update runs, bins stream back to back through a
// read-add-write pipeline on the band sum memory, with the last write forwarded
// a frame-end bin starts a frame update: a drain state, then per octave a read, a multiply
// stage, an add stage, a threshold stage and a write-back into the state memories
// write-back waits while the result register is full and m_tready is low
// reset clears control state and the per-entry valid bits, so both memories read zero
// until written; no clearing pass is needed
module octave_band_onset_detector_core
	import obod_pkg::*;
#(
	parameter int OCTAVES        = OCTAVES_DEF,
	parameter int BIN_INDEX_BITS = BIN_INDEX_BITS_DEF,
	localparam int IN_W = ((BIN_INDEX_BITS + MAG_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // bin_index, bin_magnitude
	input  logic              s_tlast,   // frame_end

	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // octave, band_active, band_event, fast_level, slow_level
	output logic              m_tlast,   // last_octave

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int AW    = $clog2(OCTAVES);
	localparam int LW    = $clog2(BIN_INDEX_BITS + 1);
	localparam int SM_W  = 2 * LEVEL_W + 1;
	localparam int PO_W  = LEVEL_W + KEEP_W;
	localparam int PN_W  = LEVEL_W + KEEP_W + 1;
	localparam int ACC_W = PN_W + 1;
	localparam int THR_W = LEVEL_W + RATIO_W;
	localparam int CMP_W = THR_W + 1;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// configuration registers
	logic [MAG_W-1:0]   noise_floor_q;
	logic [KEEP_W-1:0]  fast_keep_q;
	logic [KEEP_W-1:0]  slow_keep_q;
	logic [RATIO_W-1:0] rise_ratio_q;
	logic [RATIO_W-1:0] fall_ratio_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_floor_q <= NOISE_FLOOR_RST;
			fast_keep_q   <= FAST_KEEP_RST;
			slow_keep_q   <= SLOW_KEEP_RST;
			rise_ratio_q  <= RISE_RATIO_RST;
			fall_ratio_q  <= FALL_RATIO_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_NOISE_FLOOR: noise_floor_q <= pwdata[MAG_W-1:0];
				REG_FAST_KEEP:   fast_keep_q   <= pwdata[KEEP_W-1:0];
				REG_SLOW_KEEP:   slow_keep_q   <= pwdata[KEEP_W-1:0];
				REG_RISE_RATIO:  rise_ratio_q  <= pwdata[RATIO_W-1:0];
				REG_FALL_RATIO:  fall_ratio_q  <= pwdata[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_NOISE_FLOOR: prdata = APB_DW'(noise_floor_q);
			REG_FAST_KEEP:   prdata = APB_DW'(fast_keep_q);
			REG_SLOW_KEEP:   prdata = APB_DW'(slow_keep_q);
			REG_RISE_RATIO:  prdata = APB_DW'(rise_ratio_q);
			REG_FALL_RATIO:  prdata = APB_DW'(fall_ratio_q);
			default:         prdata = '0;
		endcase
	end

	// sequencer
	state_t        state_q, state_d;
	logic [AW-1:0] idx_q;
	logic          idx_last;
	logic          in_acc;
	logic          sweep_rd;
	logic          wb_go;
	logic          out_free;

	assign idx_last = (idx_q == AW'(OCTAVES - 1));
	assign out_free = !m_tvalid || m_tready;
	assign in_acc   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc && s_tlast) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_RD;
			ST_RD:    state_d = ST_MUL;
			ST_MUL:   state_d = ST_ADD;
			ST_ADD:   state_d = ST_THR;
			ST_THR:   state_d = ST_WB;
			ST_WB:    if (out_free) state_d = idx_last ? ST_IDLE : ST_RD;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		sweep_rd = (state_q == ST_RD);
		wb_go    = (state_q == ST_WB) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (wb_go) idx_q <= idx_last ? '0 : idx_q + 1'b1;
		end
	end

	// octave of a bin: bit length of (bin - 1), bin 0 and high bins unmapped
	logic [BIN_INDEX_BITS-1:0] bin;
	logic [BIN_INDEX_BITS-1:0] bin_m1;
	logic [LW-1:0]             blen;
	logic                      oct_ok;
	logic [AW-1:0]             oct_in;

	assign bin    = s_tdata[BIN_INDEX_BITS-1:0];
	assign bin_m1 = bin - 1'b1;

	always_comb begin
		blen = '0;
		for (int k = 0; k < BIN_INDEX_BITS; k++) begin
			if (bin_m1[k]) blen = LW'(k + 1);
		end
		oct_ok = (bin != '0) && (int'(blen) < OCTAVES);
		oct_in = oct_ok ? AW'(blen) : '0;
	end

	// band sum memory with per-entry valid bits
	logic               bs_we;
	logic [AW-1:0]      bs_waddr;
	logic [LEVEL_W-1:0] bs_wdata;
	logic [AW-1:0]      bs_raddr;
	logic [LEVEL_W-1:0] bs_rdata;
	logic [OCTAVES-1:0] bs_valid_q;
	logic               bs_rvld_q;

	// accumulate stage
	logic               acc_vld_s1;
	logic [AW-1:0]      acc_oct_s1;
	logic [MAG_W-1:0]   acc_mag_s1;
	logic               fwd_vld_q;
	logic [AW-1:0]      fwd_oct_q;
	logic [LEVEL_W-1:0] fwd_sum_q;
	logic [LEVEL_W-1:0] acc_old;
	logic [LEVEL_W:0]   acc_sum;
	logic [LEVEL_W-1:0] acc_new;

	always_comb begin
		if (fwd_vld_q && fwd_oct_q == acc_oct_s1) acc_old = fwd_sum_q;
		else if (bs_rvld_q)                       acc_old = bs_rdata;
		else                                      acc_old = '0;
		acc_sum = {1'b0, acc_old} + (LEVEL_W + 1)'(acc_mag_s1);
		acc_new = acc_sum[LEVEL_W] ? LEVEL_MAX : acc_sum[LEVEL_W-1:0];
	end

	assign bs_raddr = sweep_rd ? idx_q : oct_in;
	assign bs_we    = wb_go || acc_vld_s1;
	assign bs_waddr = wb_go ? idx_q : acc_oct_s1;
	assign bs_wdata = wb_go ? '0 : acc_new;

	obod_ram #(
		.WIDTH(LEVEL_W),
		.DEPTH(OCTAVES)
	) u_band_sum (
		.clk  (clk),
		.we   (bs_we),
		.waddr(bs_waddr),
		.wdata(bs_wdata),
		.raddr(bs_raddr),
		.rdata(bs_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_valid_q <= '0;
			bs_rvld_q  <= 1'b0;
			acc_vld_s1 <= 1'b0;
			fwd_vld_q  <= 1'b0;
		end else begin
			bs_rvld_q  <= bs_valid_q[bs_raddr];
			if (bs_we) bs_valid_q[bs_waddr] <= 1'b1;
			acc_vld_s1 <= in_acc && oct_ok;
			// only the transaction right behind a write can see stale read data
			fwd_vld_q  <= acc_vld_s1 && !wb_go;
		end
	end

	always_ff @(posedge clk) begin
		acc_oct_s1 <= oct_in;
		acc_mag_s1 <= s_tdata[BIN_INDEX_BITS +: MAG_W];
		fwd_oct_q  <= acc_oct_s1;
		fwd_sum_q  <= acc_new;
	end

	// smoother memory: {active, slow, fast}
	logic               sm_we;
	logic [SM_W-1:0]    sm_wdata;
	logic [SM_W-1:0]    sm_rdata;
	logic [OCTAVES-1:0] sm_valid_q;
	logic               sm_rvld_q;

	obod_ram #(
		.WIDTH(SM_W),
		.DEPTH(OCTAVES)
	) u_smooth (
		.clk  (clk),
		.we   (sm_we),
		.waddr(idx_q),
		.wdata(sm_wdata),
		.raddr(idx_q),
		.rdata(sm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_valid_q <= '0;
			sm_rvld_q  <= 1'b0;
		end else begin
			sm_rvld_q <= sm_valid_q[idx_q];
			if (sm_we) sm_valid_q[idx_q] <= 1'b1;
		end
	end

	// smoother products
	logic [LEVEL_W-1:0] band_in;
	logic [LEVEL_W-1:0] fast_old;
	logic [LEVEL_W-1:0] slow_old;
	logic [KEEP_W:0]    fast_gain;
	logic [KEEP_W:0]    slow_gain;
	logic [PO_W-1:0]    pf_old_q, ps_old_q;
	logic [PN_W-1:0]    pf_new_q, ps_new_q;
	logic               act_q;

	assign band_in   = bs_rvld_q ? bs_rdata : '0;
	assign fast_old  = sm_rvld_q ? sm_rdata[LEVEL_W-1:0] : '0;
	assign slow_old  = sm_rvld_q ? sm_rdata[2*LEVEL_W-1:LEVEL_W] : '0;
	assign fast_gain = (KEEP_W + 1)'(1 << KEEP_W) - {1'b0, fast_keep_q};
	assign slow_gain = (KEEP_W + 1)'(1 << KEEP_W) - {1'b0, slow_keep_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			pf_old_q <= PO_W'(fast_old) * PO_W'(fast_keep_q);
			ps_old_q <= PO_W'(slow_old) * PO_W'(slow_keep_q);
			pf_new_q <= PN_W'(band_in) * PN_W'(fast_gain);
			ps_new_q <= PN_W'(band_in) * PN_W'(slow_gain);
			act_q    <= sm_rvld_q && sm_rdata[SM_W-1];
		end
	end

	// round half up, then saturate
	logic [ACC_W-1:0]   fast_acc, slow_acc;
	logic [LEVEL_W-1:0] fast_new_q, slow_new_q;

	assign fast_acc = ACC_W'(pf_old_q) + ACC_W'(pf_new_q) + ACC_W'(1 << (KEEP_W - 1));
	assign slow_acc = ACC_W'(ps_old_q) + ACC_W'(ps_new_q) + ACC_W'(1 << (KEEP_W - 1));

	always_ff @(posedge clk) begin
		if (state_q == ST_ADD) begin
			fast_new_q <= (|fast_acc[ACC_W-1:KEEP_W+LEVEL_W]) ? LEVEL_MAX
			              : fast_acc[KEEP_W +: LEVEL_W];
			slow_new_q <= (|slow_acc[ACC_W-1:KEEP_W+LEVEL_W]) ? LEVEL_MAX
			              : slow_acc[KEEP_W +: LEVEL_W];
		end
	end

	// thresholds
	logic [THR_W-1:0]          up_q, dn_q;
	logic signed [LEVEL_W:0]   lvl_q;
	logic signed [CMP_W-1:0]   lvl_x256;

	always_ff @(posedge clk) begin
		if (state_q == ST_THR) begin
			up_q  <= THR_W'(slow_new_q) * THR_W'(rise_ratio_q);
			dn_q  <= THR_W'(slow_new_q) * THR_W'(fall_ratio_q);
			lvl_q <= $signed({1'b0, fast_new_q}) - $signed((LEVEL_W + 1)'(noise_floor_q));
		end
	end

	// level below the noise floor stays negative
	assign lvl_x256 = {{(CMP_W - LEVEL_W - 9){lvl_q[LEVEL_W]}}, lvl_q, 8'b0};

	// decision and write-back
	logic        onset, release_ev;
	logic        act_new;
	band_event_t ev;

	always_comb begin
		onset      = !act_q && (lvl_x256 > $signed({1'b0, up_q}));
		release_ev = act_q && (lvl_x256 < $signed({1'b0, dn_q}));
		if (onset) begin
			act_new = 1'b1;
			ev      = EV_ONSET;
		end else if (release_ev) begin
			act_new = 1'b0;
			ev      = EV_RELEASE;
		end else begin
			act_new = act_q;
			ev      = EV_NONE;
		end
	end

	assign sm_we    = wb_go;
	assign sm_wdata = {act_new, slow_new_q, fast_new_q};

	// result register
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (wb_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			m_tdata_q <= OUT_W'({slow_new_q, fast_new_q, ev, act_new, OCT_FIELD_W'(idx_q)});
			m_tlast_q <= idx_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- sim/tb_octave_band_onset_detector_core.sv -----
`timescale 1ns / 1ps

module tb_octave_band_onset_detector_core;
	import obod_pkg::*;

	localparam int OCT         = OCTAVES_DEF;
	localparam int BIN_W       = BIN_INDEX_BITS_DEF;
	localparam int IN_W        = ((BIN_W + MAG_W + 7) / 8) * 8;
	localparam int FRAME_LAT   = 2 + 5 * OCT + 8;
	localparam int REG_UNMAPPED = 7;
	localparam logic [63:0] LEVEL_MAX = (64'd1 << LEVEL_W) - 64'd1;

	typedef struct {
		logic [OCT_FIELD_W-1:0] octave;
		logic                   active;
		band_event_t            ev;
		logic [LEVEL_W-1:0]     fast;
		logic [LEVEL_W-1:0]     slow;
		logic                   last;
	} band_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;   // bin_index, bin_magnitude
	logic              s_tlast = 1'b0; // frame_end
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;        // octave, band_active, band_event, fast_level, slow_level
	logic              m_tlast;        // last_octave
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	octave_band_onset_detector_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// detector state mirrored on the testbench side
	logic [LEVEL_W-1:0] energy_acc [OCT];
	logic [LEVEL_W-1:0] fast_lvl [OCT];
	logic [LEVEL_W-1:0] slow_lvl [OCT];
	logic               band_on [OCT];
	logic [MAG_W-1:0]   floor_cfg;
	logic [KEEP_W-1:0]  fast_keep_cfg;
	logic [KEEP_W-1:0]  slow_keep_cfg;
	logic [RATIO_W-1:0] rise_cfg;
	logic [RATIO_W-1:0] fall_cfg;

	band_result_t expected_bands [$];
	int mismatch_count = 0;
	int bins_sent = 0;
	int bands_seen = 0;
	int onsets_seen = 0;
	int releases_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d band results outstanding", expected_bands.size());
		$display("Test completed with failures");
		$finish;
	end

	function automatic int band_of_bin(input logic [BIN_W-1:0] b);
		if (b == 1)
			return 0;
		for (int i = 1; i < OCT; i++)
			if (b > (1 << (i - 1)) && b <= (1 << i))
				return i;
		return -1;
	endfunction

	// round half up, clamp to the level width
	function automatic logic [LEVEL_W-1:0] smooth_level(input logic [LEVEL_W-1:0] prev,
			input logic [LEVEL_W-1:0] energy, input logic [KEEP_W-1:0] keep);
		logic [63:0] acc;
		acc = 64'(prev) * 64'(keep) + 64'(energy) * (64'd65536 - 64'(keep)) + 64'd32768;
		acc = acc >> 16;
		if (acc > LEVEL_MAX)
			acc = LEVEL_MAX;
		return acc[LEVEL_W-1:0];
	endfunction

	function automatic void predict_bin(input logic [BIN_W-1:0] idx, input logic [MAG_W-1:0] mag,
			input logic fend);
		int b;
		logic [63:0] s;
		longint d, up, dn;
		band_result_t r;
		b = band_of_bin(idx);
		if (b >= 0) begin
			s = 64'(energy_acc[b]) + 64'(mag);
			energy_acc[b] = (s > LEVEL_MAX) ? LEVEL_MAX[LEVEL_W-1:0] : s[LEVEL_W-1:0];
		end
		if (!fend)
			return;
		for (int i = 0; i < OCT; i++) begin
			fast_lvl[i] = smooth_level(fast_lvl[i], energy_acc[i], fast_keep_cfg);
			slow_lvl[i] = smooth_level(slow_lvl[i], energy_acc[i], slow_keep_cfg);
			energy_acc[i] = '0;
			d = (longint'(fast_lvl[i]) - longint'(floor_cfg)) * 256;
			up = longint'(slow_lvl[i]) * longint'(rise_cfg);
			dn = longint'(slow_lvl[i]) * longint'(fall_cfg);
			r.ev = EV_NONE;
			if (!band_on[i] && d > up) begin
				band_on[i] = 1'b1;
				r.ev = EV_ONSET;
			end else if (band_on[i] && d < dn) begin
				band_on[i] = 1'b0;
				r.ev = EV_RELEASE;
			end
			r.octave = OCT_FIELD_W'(i);
			r.active = band_on[i];
			r.fast = fast_lvl[i];
			r.slow = slow_lvl[i];
			r.last = (i == OCT - 1);
			expected_bands = {expected_bands, r};
		end
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		band_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			bands_seen++;
			if (expected_bands.size() == 0) begin
				$error("result transaction with nothing expected, tdata %h", m_tdata);
				mismatch_count++;
			end else begin
				want = expected_bands.pop_front();
				if (m_tdata[3:0] !== want.octave) begin
					$error("octave: expected %0d, got %0d", want.octave, m_tdata[3:0]);
					mismatch_count++;
				end
				if (m_tdata[4] !== want.active) begin
					$error("band_active: expected %0d, got %0d", want.active, m_tdata[4]);
					mismatch_count++;
				end
				if (m_tdata[6:5] !== want.ev) begin
					$error("band_event: expected %0d, got %0d", want.ev, m_tdata[6:5]);
					mismatch_count++;
				end
				if (m_tdata[31:7] !== want.fast) begin
					$error("fast_level: expected %0d, got %0d", want.fast, m_tdata[31:7]);
					mismatch_count++;
				end
				if (m_tdata[56:32] !== want.slow) begin
					$error("slow_level: expected %0d, got %0d", want.slow, m_tdata[56:32]);
					mismatch_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last_octave: expected %0d, got %0d", want.last, m_tlast);
					mismatch_count++;
				end
				if (m_tdata[OUT_W-1:57] !== '0) begin
					$error("tdata padding: expected 0, got %h", m_tdata[OUT_W-1:57]);
					mismatch_count++;
				end
				if (want.ev == EV_ONSET)
					onsets_seen++;
				if (want.ev == EV_RELEASE)
					releases_seen++;
			end
		end
	end

	task automatic send_bin(input logic [BIN_W-1:0] idx, input logic [MAG_W-1:0] mag,
			input logic fend);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - BIN_W - MAG_W){1'b0}}, mag, idx};
		s_tlast <= fend;
		do @(posedge clk); while (!s_tready);
		predict_bin(idx, mag, fend);
		bins_sent++;
	endtask

	// all results in, then let a frame update that might still be running finish
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_bands.size() != 0)
			@(posedge clk);
		repeat (FRAME_LAT) @(posedge clk);
	endtask

	// leaves psel high; release_bus ends a burst of transfers
	task automatic apb_access(input int idx, input logic wr, input logic [APB_DW-1:0] val);
		logic [APB_DW-1:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_AW'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_NOISE_FLOOR: want = APB_DW'(floor_cfg);
			REG_FAST_KEEP:   want = APB_DW'(fast_keep_cfg);
			REG_SLOW_KEEP:   want = APB_DW'(slow_keep_cfg);
			REG_RISE_RATIO:  want = APB_DW'(rise_cfg);
			REG_FALL_RATIO:  want = APB_DW'(fall_cfg);
			default:         want = '0;
		endcase
		if (wr) begin
			case (idx)
				REG_NOISE_FLOOR: floor_cfg = val[MAG_W-1:0];
				REG_FAST_KEEP:   fast_keep_cfg = val[KEEP_W-1:0];
				REG_SLOW_KEEP:   slow_keep_cfg = val[KEEP_W-1:0];
				REG_RISE_RATIO:  rise_cfg = val[RATIO_W-1:0];
				REG_FALL_RATIO:  fall_cfg = val[RATIO_W-1:0];
				default: ;
			endcase
		end else if (prdata !== want) begin
			$error("prdata reg %0d: expected %0d, got %0d", idx, want, prdata);
			mismatch_count++;
		end
	endtask

	task automatic release_bus();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_thresholds(input logic [15:0] nf, input logic [15:0] fk,
			input logic [15:0] sk, input logic [9:0] rr, input logic [9:0] fr);
		apb_access(REG_NOISE_FLOOR, 1'b1, APB_DW'(nf));
		apb_access(REG_FAST_KEEP, 1'b1, APB_DW'(fk));
		apb_access(REG_SLOW_KEEP, 1'b1, APB_DW'(sk));
		apb_access(REG_RISE_RATIO, 1'b1, APB_DW'(rr));
		apb_access(REG_FALL_RATIO, 1'b1, APB_DW'(fr));
		for (int i = REG_NOISE_FLOOR; i <= REG_FALL_RATIO; i++)
			apb_access(i, 1'b0, '0);
		release_bus();
	endtask

	// boundaries of the octave map, ignored bins, full-scale magnitudes, empty frames
	task automatic test_directed_bins();
		send_bin(10'd0, 16'hFFFF, 1'b0);
		send_bin(10'd1, 16'hFFFF, 1'b0);
		send_bin(10'd2, 16'h0000, 1'b0);
		send_bin(10'd3, 16'h1234, 1'b0);
		send_bin(10'd4, 16'hFFFF, 1'b0);
		send_bin(10'd256, 16'hFFFF, 1'b0);
		send_bin(10'd257, 16'h00FF, 1'b0);
		send_bin(10'd512, 16'hFFFF, 1'b0);
		send_bin(10'd513, 16'hFFFF, 1'b0);
		send_bin(10'd1023, 16'hFFFF, 1'b1);
		send_bin(10'd0, 16'h0000, 1'b1);
		send_bin(10'd5, 16'hFFFF, 1'b0);
		send_bin(10'd100, 16'hFFFF, 1'b0);
		send_bin(10'd300, 16'hFFFF, 1'b1);
		send_bin(10'd1, 16'hFFFF, 1'b1);
		for (int k = 0; k < 6; k++)
			send_bin(10'd0, 16'h0000, 1'b1);
		send_bin(10'd128, 16'h8000, 1'b1);
		wait_drained();
	endtask

	// a run of full-scale bins into the top octave builds a large band sum
	task automatic test_full_scale_bins();
		for (int k = 0; k < 40; k++)
			send_bin(BIN_W'(257 + k * 6), 16'hFFFF, k == 39);
		wait_drained();
	endtask

	task automatic test_register_access();
		program_thresholds(16'hA5C3, 16'h5A3C, 16'hC3A5, 10'h2B5, 10'h14A);
		apb_access(REG_UNMAPPED, 1'b1, $urandom);
		apb_access(REG_UNMAPPED - 1, 1'b1, $urandom);
		for (int i = REG_NOISE_FLOOR; i <= REG_FALL_RATIO; i++)
			apb_access(i, 1'b0, '0);
		release_bus();
	endtask

	// frames of random length with quiet, moderate and loud energy so bands rise and fall
	task automatic test_random_frames(input int n_bins, input int gap_pct, input int stall_pct);
		int sent;
		int len;
		int kind;
		int oct;
		logic [BIN_W-1:0] b;
		logic [MAG_W-1:0] m;
		send_idle_pct = gap_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_bins) begin
			len = ($urandom_range(3) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
			kind = $urandom_range(2);
			for (int k = 0; k < len; k++) begin
				oct = $urandom_range(OCT - 1);
				if ($urandom_range(9) == 0)
					b = ($urandom_range(1) == 0) ? '0 : BIN_W'($urandom_range(513, 1023));
				else if (oct == 0)
					b = BIN_W'(1);
				else
					b = BIN_W'($urandom_range((1 << (oct - 1)) + 1, 1 << oct));
				case (kind)
					0:       m = ($urandom_range(4) == 0) ? 16'h0000 : MAG_W'($urandom_range(255));
					1:       m = MAG_W'($urandom_range(16'h0FFF));
					default: m = ($urandom_range(4) == 0) ? 16'hFFFF : MAG_W'($urandom);
				endcase
				send_bin(b, m, k == len - 1);
			end
			sent += len;
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < OCT; i++) begin
			energy_acc[i] = '0;
			fast_lvl[i] = '0;
			slow_lvl[i] = '0;
			band_on[i] = 1'b0;
		end
		floor_cfg = NOISE_FLOOR_RST;
		fast_keep_cfg = FAST_KEEP_RST;
		slow_keep_cfg = SLOW_KEEP_RST;
		rise_cfg = RISE_RATIO_RST;
		fall_cfg = FALL_RATIO_RST;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_bins();
		test_full_scale_bins();
		test_register_access();
		program_thresholds(16'd0, 16'd49152, 16'd64881, 10'd294, 10'd230);
		test_random_frames(36, 0, 0);
		program_thresholds(16'hFFFF, 16'd0, 16'hFFFF, 10'd0, 10'h3FF);
		test_random_frames(36, 81, 0);
		program_thresholds(16'd0, 16'hFFFF, 16'd0, 10'h3FF, 10'd0);
		test_random_frames(36, 0, 81);
		program_thresholds(MAG_W'($urandom_range(2048)), KEEP_W'($urandom_range(16'hE000)),
			KEEP_W'($urandom_range(16'hC000, 16'hFFFF)), RATIO_W'($urandom_range(256, 400)),
			RATIO_W'($urandom_range(128, 255)));
		test_random_frames(36, 23, 23);

		$display("sent %0d bins, checked %0d band results (%0d onsets, %0d releases)",
			bins_sent, bands_seen, onsets_seen, releases_seen);
		$display("covered octave boundaries, full-scale band sums, register access, four pacing mixes");
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
